// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk_s, rst_ns, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_ns) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk_s, prop, msg) \
    label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== src/wtsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wtsp_pkg
// Constants and register codes for the world-to-screen projection block.
// ----------------------------------------------------------------------------
package wtsp_pkg;

    localparam int MAT_W       = 32;      // matrix entry width
    localparam int VIEW_W      = 14;      // screen size register width
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int INV_SCALE_W = 18;
    localparam logic signed [INV_SCALE_W-1:0] INV_SCALE = 18'sd100000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_A = 3'd0,
        REG_ROW0_B = 3'd1,
        REG_ROW1_A = 3'd2,
        REG_ROW1_B = 3'd3,
        REG_ROW3_A = 3'd4,
        REG_ROW3_B = 3'd5,
        REG_VIEW_W = 3'd6,
        REG_VIEW_H = 3'd7
    } cfg_reg_t;

endpackage

// ===== src/world_to_screen_projection.sv =====
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Pipelined perspective projection of world points to pixel coordinates.
// ----------------------------------------------------------------------------
// One point word per cycle enters; each result word leaves from the output
// register at the end of the pipe. The pipe's length is set by the restoring
// divider, which resolves one quotient bit per stage for the x and y lanes
// side by side. Four front stages do the matrix products, the dot product
// sums, the size scaling and the magnitude / overflow setup; a final stage
// adds the screen center and saturates. The whole pipe advances together: it
// stalls only while a result word sits at the output unaccepted, and then
// in_ready drops. Matrix and view size must be written while the pipe is
// empty; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module world_to_screen_projection
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    // point input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          visible,
    output logic signed [COORD_WIDTH-1:0] screen_x,
    output logic signed [COORD_WIDTH-1:0] screen_y
);

    localparam int F   = FRAC_BITS;
    localparam int CW  = COORD_WIDTH;
    localparam int PW  = MAT_W + CW;          // one matrix product
    localparam int AW  = PW + 2;              // sum of four terms
    localparam int CLW = AW - F;              // clip coordinate
    localparam int SPW = CLW + VIEW_W + 1;    // clip * size, signed
    localparam int MGW = CLW + VIEW_W;        // its magnitude
    localparam int NW  = MGW + F;             // dividend
    localparam int QB  = ((CW > VIEW_W + F) ? CW : VIEW_W + F) + 2;  // quotient bits
    localparam int RW  = CLW + 1;             // partial remainder
    localparam int IW  = CLW + INV_SCALE_W;   // clip * 100000
    localparam int SW  = QB + 2;              // final sum
    localparam int NST = QB + 5;              // valid bits along the pipe
    localparam int THR = (1 << F) / 1000 + 1; // w > 0.001

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] mat_reg [6];
    logic [VIEW_W-1:0]     view_w_reg;
    logic [VIEW_W-1:0]     view_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= 64'd65536;
            mat_reg[1] <= '0;
            mat_reg[2] <= 64'd65536 << 32;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= 64'd65536 << 32;
            view_w_reg <= 14'd1920;
            view_h_reg <= 14'd1080;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW0_A: mat_reg[0] <= cfg_data;
                REG_ROW0_B: mat_reg[1] <= cfg_data;
                REG_ROW1_A: mat_reg[2] <= cfg_data;
                REG_ROW1_B: mat_reg[3] <= cfg_data;
                REG_ROW3_A: mat_reg[4] <= cfg_data;
                REG_ROW3_B: mat_reg[5] <= cfg_data;
                REG_VIEW_W: view_w_reg <= cfg_data[VIEW_W-1:0];
                REG_VIEW_H: view_h_reg <= cfg_data[VIEW_W-1:0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipe control: everything moves unless the output word is stuck
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic           adv;

    assign adv      = !vld_reg[NST-1] || out_ready;
    assign in_ready = adv;
    assign vld_next = {vld_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // ------------------------------------------------------------------
    // Stage 1: nine products (rows 0, 1, 3 times x, y, z)
    // ------------------------------------------------------------------
    logic signed [MAT_W-1:0] m_ent [3][4];
    logic signed [CW-1:0]    pt    [3];
    logic signed [PW-1:0]    prod_reg [3][3];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            m_ent[r][0] = mat_reg[2*r][MAT_W-1:0];
            m_ent[r][1] = mat_reg[2*r][2*MAT_W-1:MAT_W];
            m_ent[r][2] = mat_reg[2*r+1][MAT_W-1:0];
            m_ent[r][3] = mat_reg[2*r+1][2*MAT_W-1:MAT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= PW'(m_ent[r][c] * pt[c]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: dot products, floor shift to clip coordinates
    // ------------------------------------------------------------------
    logic signed [AW-1:0]  acc  [3];
    logic signed [CLW-1:0] clip_reg [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            acc[r] = AW'(prod_reg[r][0]) + AW'(prod_reg[r][1]) + AW'(prod_reg[r][2])
                   + (AW'(m_ent[r][3]) <<< F);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
                clip_reg[r] <= acc[r][AW-1:F];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: visibility, size scaling, behind-view scaling
    // ------------------------------------------------------------------
    logic                  s3_vis_reg;
    logic signed [SPW-1:0] s3_spx_reg, s3_spy_reg;
    logic signed [IW-1:0]  s3_ivx_reg, s3_ivy_reg;
    logic [CLW-1:0]        s3_d_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_vis_reg <= clip_reg[2] >= $signed(CLW'(THR));
            s3_spx_reg <= SPW'(clip_reg[0] * $signed({1'b0, view_w_reg}));
            s3_spy_reg <= SPW'(clip_reg[1] * $signed({1'b0, view_h_reg}));
            s3_ivx_reg <= IW'(clip_reg[0] * INV_SCALE);
            s3_ivy_reg <= IW'(clip_reg[1] * INV_SCALE);
            s3_d_reg   <= {clip_reg[2][CLW-2:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitudes, quotient overflow, saturated behind-view values
    // ------------------------------------------------------------------
    function automatic logic signed [CW-1:0] sat_iw(input logic signed [IW-1:0] v);
        logic signed [CW-1:0] r;
        if (v[IW-1:CW-1] == '0 || v[IW-1:CW-1] == '1)
            r = v[CW-1:0];
        else
            r = v[IW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [CW-1:0] sat_sw(input logic signed [SW-1:0] v);
        logic signed [CW-1:0] r;
        if (v[SW-1:CW-1] == '0 || v[SW-1:CW-1] == '1)
            r = v[CW-1:0];
        else
            r = v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        return r;
    endfunction

    logic [SPW-1:0] absx, absy;
    logic [NW-1:0]  numx, numy;

    assign absx = s3_spx_reg[SPW-1] ? SPW'(-s3_spx_reg) : s3_spx_reg;
    assign absy = s3_spy_reg[SPW-1] ? SPW'(-s3_spy_reg) : s3_spy_reg;
    assign numx = {absx[MGW-1:0], {F{1'b0}}};
    assign numy = {absy[MGW-1:0], {F{1'b0}}};

    // divider lanes, index 0 is loaded here, index QB is the last step
    logic                 dv_vis_reg  [QB+1];
    logic                 dv_negx_reg [QB+1];
    logic                 dv_negy_reg [QB+1];
    logic                 dv_ovfx_reg [QB+1];
    logic                 dv_ovfy_reg [QB+1];
    logic [CLW-1:0]       dv_d_reg    [QB+1];
    logic [RW-1:0]        dv_rx_reg   [QB+1];
    logic [RW-1:0]        dv_ry_reg   [QB+1];
    logic [QB-1:0]        dv_lx_reg   [QB+1];
    logic [QB-1:0]        dv_ly_reg   [QB+1];
    logic [QB-1:0]        dv_qx_reg   [QB+1];
    logic [QB-1:0]        dv_qy_reg   [QB+1];
    logic signed [CW-1:0] dv_ix_reg   [QB+1];
    logic signed [CW-1:0] dv_iy_reg   [QB+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_vis_reg[0]  <= s3_vis_reg;
            dv_negx_reg[0] <= s3_spx_reg[SPW-1];
            dv_negy_reg[0] <= s3_spy_reg[SPW-1];
            // quotient too wide for QB bits: result saturates anyway
            dv_ovfx_reg[0] <= CLW'(numx[NW-1:QB]) >= s3_d_reg;
            dv_ovfy_reg[0] <= CLW'(numy[NW-1:QB]) >= s3_d_reg;
            dv_d_reg[0]    <= s3_d_reg;
            dv_rx_reg[0]   <= RW'(numx[NW-1:QB]);
            dv_ry_reg[0]   <= RW'(numy[NW-1:QB]);
            dv_lx_reg[0]   <= numx[QB-1:0];
            dv_ly_reg[0]   <= numy[QB-1:0];
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
            dv_ix_reg[0]   <= sat_iw(s3_ivx_reg);
            dv_iy_reg[0]   <= sat_iw(s3_ivy_reg);
        end
    end

    // ------------------------------------------------------------------
    // Divider: one restoring step per stage, x and y lanes
    // ------------------------------------------------------------------
    for (genvar i = 0; i < QB; i++)
    begin : g_div
        logic [RW-1:0] tx, ty;
        logic          gex, gey;

        assign tx  = {dv_rx_reg[i][RW-2:0], dv_lx_reg[i][QB-1]};
        assign ty  = {dv_ry_reg[i][RW-2:0], dv_ly_reg[i][QB-1]};
        assign gex = tx >= RW'(dv_d_reg[i]);
        assign gey = ty >= RW'(dv_d_reg[i]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_vis_reg[i+1]  <= dv_vis_reg[i];
                dv_negx_reg[i+1] <= dv_negx_reg[i];
                dv_negy_reg[i+1] <= dv_negy_reg[i];
                dv_ovfx_reg[i+1] <= dv_ovfx_reg[i];
                dv_ovfy_reg[i+1] <= dv_ovfy_reg[i];
                dv_d_reg[i+1]    <= dv_d_reg[i];
                dv_rx_reg[i+1]   <= gex ? tx - RW'(dv_d_reg[i]) : tx;
                dv_ry_reg[i+1]   <= gey ? ty - RW'(dv_d_reg[i]) : ty;
                dv_lx_reg[i+1]   <= {dv_lx_reg[i][QB-2:0], 1'b0};
                dv_ly_reg[i+1]   <= {dv_ly_reg[i][QB-2:0], 1'b0};
                dv_qx_reg[i+1]   <= {dv_qx_reg[i][QB-2:0], gex};
                dv_qy_reg[i+1]   <= {dv_qy_reg[i][QB-2:0], gey};
                dv_ix_reg[i+1]   <= dv_ix_reg[i];
                dv_iy_reg[i+1]   <= dv_iy_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: center offset, rounding half, saturation
    // ------------------------------------------------------------------
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);
    localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

    logic signed [SW-1:0] sqx, sqy, cx, cy, sumx, sumy;
    logic signed [CW-1:0] pix_x, pix_y;
    logic                 out_vis_reg;
    logic signed [CW-1:0] out_x_reg, out_y_reg;

    assign sqx  = dv_negx_reg[QB] ? -SW'(dv_qx_reg[QB]) : SW'(dv_qx_reg[QB]);
    assign sqy  = dv_negy_reg[QB] ? -SW'(dv_qy_reg[QB]) : SW'(dv_qy_reg[QB]);
    assign cx   = SW'(view_w_reg[VIEW_W-1:1]) <<< F;
    assign cy   = SW'(view_h_reg[VIEW_W-1:1]) <<< F;
    assign sumx = cx + sqx + HALF;
    assign sumy = cy - (sqy + HALF);

    always_comb
    begin
        if (dv_ovfx_reg[QB])
            pix_x = dv_negx_reg[QB] ? SAT_MIN : SAT_MAX;
        else
            pix_x = sat_sw(sumx);
        if (dv_ovfy_reg[QB])
            pix_y = dv_negy_reg[QB] ? SAT_MAX : SAT_MIN;
        else
            pix_y = sat_sw(sumy);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_vis_reg <= dv_vis_reg[QB];
            out_x_reg   <= dv_vis_reg[QB] ? pix_x : dv_ix_reg[QB];
            out_y_reg   <= dv_vis_reg[QB] ? pix_y : dv_iy_reg[QB];
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign visible   = out_vis_reg;
    assign screen_x  = out_x_reg;
    assign screen_y  = out_y_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_stall_blocks_input, clk, rst_n, out_valid && !out_ready |-> !in_ready, "input taken while output stalled")
    `ASSERT_CLK(a_stall_freezes_pipe, clk, rst_n, !adv |=> $stable(vld_reg), "pipe valids moved during stall")
    `ASSERT_CLK(a_rem_below_div, clk, rst_n, vld_reg[NST-2] && !dv_ovfx_reg[QB] |-> dv_rx_reg[QB] < RW'(dv_d_reg[QB]), "divider remainder not below divisor")

endmodule
